[rtl/core/cba_pkg.sv]
// Shared types and codes for the contiguous block allocator.
package cba_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned FLD_W = 7;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

  typedef struct packed {
    logic             relocated;
    logic [FLD_W-1:0] placed_start;
    logic             status;
  } res_t;

endpackage

[rtl/core/cba_ram.sv]
// Generic simple dual-port RAM with registered read.
module cba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/cba_seq.sv]
// Sequencer that scans, checks and rewrites the block bitmap held in RAM.
module cba_seq import cba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 128,
  localparam int unsigned AW = $clog2(NUM_BLOCKS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OP_W-1:0]  op_i,
  input  logic [FLD_W-1:0] run_start_i,
  input  logic [FLD_W-1:0] run_length_i,
  input  logic [FLD_W-1:0] target_length_i,
  output logic             done_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic             mem_wdata_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  logic             mem_rdata_i
);

  // position counter also holds run_start + run_length and the end marker
  localparam int unsigned CW = (AW + 1 > FLD_W + 1) ? AW + 1 : FLD_W + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [FLD_W-1:0] rem_q, rem_d;
  logic             val_q, val_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_pos_q, pend_pos_d;
  logic [FLD_W-1:0] run_q, run_d;
  logic [FLD_W-1:0] need_q, need_d;
  logic [FLD_W-1:0] start_q, start_d;
  logic [FLD_W-1:0] len_q, len_d;
  logic             reloc_q, reloc_d;
  logic             sec_q, sec_d;
  logic [CW-1:0]    sec_pos_q, sec_pos_d;
  res_t             res_q, res_d;

  logic             used;
  logic             at_end;
  logic [FLD_W:0]   run_inc;
  logic             hit;
  logic             last;
  logic [CW-1:0]    found;

  // block 0 is reserved and always reads as used
  assign used    = mem_rdata_i || (pend_pos_q == '0);
  assign at_end  = pos_q >= CW'(NUM_BLOCKS);
  assign run_inc = {1'b0, run_q} + {{FLD_W{1'b0}}, 1'b1};
  assign hit     = !used && (run_inc == {1'b0, need_q});
  assign last    = pend_pos_q == AW'(NUM_BLOCKS - 1);
  assign found   = CW'(pend_pos_q) - CW'(need_q) + CW'(1);

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    val_d      = val_q;
    pend_d     = 1'b0;
    pend_pos_d = pend_pos_q;
    run_d      = run_q;
    need_d     = need_q;
    start_d    = start_q;
    len_d      = len_q;
    reloc_d    = reloc_q;
    sec_d      = sec_q;
    sec_pos_d  = sec_pos_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    mem_we_o   = 1'b0;
    mem_wdata_o = val_q;
    mem_re_o   = 1'b0;

    unique case (state_q)
      S_CLR: begin
        // leave the reserved entry alone, logic holds it as used
        mem_we_o    = pos_q != '0;
        mem_wdata_o = 1'b0;
        pos_d       = pos_q + CW'(1);
        if (pos_q == CW'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          start_d = run_start_i;
          len_d   = run_length_i;
          need_d  = target_length_i;
          reloc_d = 1'b0;
          sec_d   = 1'b0;
          run_d   = '0;
          res_d   = '{relocated: 1'b0, placed_start: '0, status: 1'b1};
          unique case (op_i)
            OP_ALLOC: begin
              need_d = run_length_i;
              if (run_length_i == '0) begin
                res_d.status = 1'b0;
                state_d      = S_DONE;
              end else begin
                pos_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_FREE: begin
              pos_d   = CW'(run_start_i);
              rem_d   = run_length_i;
              val_d   = 1'b0;
              res_d   = '{relocated: 1'b0, placed_start: run_start_i, status: 1'b0};
              state_d = S_WR;
            end
            OP_RESIZE: begin
              if (target_length_i <= run_length_i) begin
                // shrink: free the tail
                pos_d   = CW'(run_start_i) + CW'(target_length_i);
                rem_d   = run_length_i - target_length_i;
                val_d   = 1'b0;
                res_d   = '{relocated: 1'b0, placed_start: run_start_i, status: 1'b0};
                state_d = S_WR;
              end else begin
                pos_d   = CW'(run_start_i) + CW'(run_length_i);
                rem_d   = target_length_i - run_length_i;
                state_d = S_CHK;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_CHK: begin
        if ((pend_q && used) || (rem_q != '0 && at_end)) begin
          // no room in place: search for a new run while the old one is held
          pos_d   = '0;
          run_d   = '0;
          reloc_d = 1'b1;
          state_d = S_SCAN;
        end else if (rem_q == '0 && !pend_q) begin
          pos_d   = CW'(start_q) + CW'(len_q);
          rem_d   = need_q - len_q;
          val_d   = 1'b1;
          res_d   = '{relocated: 1'b0, placed_start: start_q, status: 1'b0};
          state_d = S_WR;
        end else if (rem_q != '0) begin
          mem_re_o   = 1'b1;
          pend_d     = 1'b1;
          pend_pos_d = pos_q[AW-1:0];
          pos_d      = pos_q + CW'(1);
          rem_d      = rem_q - FLD_W'(1);
        end
      end

      S_SCAN: begin
        if (pend_q && hit) begin
          state_d = S_WR;
          res_d   = '{relocated: reloc_q, placed_start: found[FLD_W-1:0], status: 1'b0};
          if (reloc_q) begin
            // free the old run first, then mark the new one
            pos_d     = CW'(start_q);
            rem_d     = len_q;
            val_d     = 1'b0;
            sec_d     = 1'b1;
            sec_pos_d = found;
          end else begin
            pos_d = found;
            rem_d = need_q;
            val_d = 1'b1;
          end
        end else if (pend_q && last) begin
          res_d   = '{relocated: 1'b0, placed_start: '0, status: 1'b1};
          state_d = S_DONE;
        end else begin
          if (pend_q) begin
            run_d = used ? '0 : run_inc[FLD_W-1:0];
          end
          if (!at_end) begin
            mem_re_o   = 1'b1;
            pend_d     = 1'b1;
            pend_pos_d = pos_q[AW-1:0];
            pos_d      = pos_q + CW'(1);
          end
        end
      end

      S_WR: begin
        if (rem_q == '0 || at_end) begin
          if (sec_q) begin
            pos_d = sec_pos_q;
            rem_d = need_q;
            val_d = 1'b1;
            sec_d = 1'b0;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          mem_we_o = pos_q != '0;
          pos_d    = pos_q + CW'(1);
          rem_d    = rem_q - FLD_W'(1);
        end
      end

      S_DONE: begin
        done_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = pos_q[AW-1:0];
  assign mem_raddr_o = pos_q[AW-1:0];
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pos_q   <= '0;
      pend_q  <= 1'b0;
      sec_q   <= 1'b0;
      reloc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      sec_q   <= sec_d;
      reloc_q <= reloc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    val_q      <= val_d;
    pend_pos_q <= pend_pos_d;
    run_q      <= run_d;
    need_q     <= need_d;
    start_q    <= start_d;
    len_q      <= len_d;
    sec_pos_q  <= sec_pos_d;
    res_q      <= res_d;
  end

endmodule

[rtl/core/contiguous_block_allocator_core.sv]
// Top level of the first-fit contiguous block allocator.
// Usage: one request item enters on the s_axis channel (op, run_start,
// run_length, target_length) and exactly one result item leaves on the
// m_axis channel (status, placed_start, relocated). Items are handled one
// at a time; s_axis_tready is high only while the sequencer is idle.
// Timing is set by the scan of the bitmap RAM, one block per cycle, through
// a registered read. The steps from acceptance to m_axis_tvalid:
//   allocate: a search of the bitmap, then the blocks found are marked
//   free / shrink: the blocks are cleared
//   grow in place: the blocks past the run are checked, then marked
//   relocate: the blocks past the run are checked, the search as above, then
//   the old blocks are freed and the new blocks are marked
//   zero-size allocate or unused op: no access to the bitmap
// The next item can be accepted in the cycle after the result is loaded.
// After reset a clearing pass writes every RAM entry but block 0, during
// which no item is accepted. Block 0 is held as used by logic.
// Results sit in an output register; a stalled receiver holds it, and the
// next request is still accepted and worked on, waiting only to deliver.
module contiguous_block_allocator_core import cba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] op, [8:2] run_start, [15:9] run_length, [22:16] target_length
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] status, [7:1] placed_start, [8] relocated
  output logic [15:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);

  logic          done;
  logic          res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;
  logic          out_valid_q, out_valid_d;
  res_t          out_q;

  cba_seq #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .op_i           (s_axis_tdata_i[1:0]),
    .run_start_i    (s_axis_tdata_i[8:2]),
    .run_length_i   (s_axis_tdata_i[15:9]),
    .target_length_i(s_axis_tdata_i[22:16]),
    .done_o         (done),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  cba_ram #(
    .WIDTH(1),
    .DEPTH(NUM_BLOCKS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // load a new result when the output register is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (done && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.relocated, out_q.placed_start, out_q.status};

  // the reserved block is never rewritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> mem_waddr != '0)
    else $error("write to reserved block");

  // the bitmap is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("read and write overlap on bitmap");

  // a failed request reports no start and no move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |->
      (m_axis_tdata_o[7:1] == '0 && !m_axis_tdata_o[8]))
    else $error("failure result carries data");

  // no request is taken while the sequencer holds an undelivered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !s_axis_tready_o)
    else $error("request accepted while result pending");

endmodule
